// ----- sv/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// scc_pkg: shared types and constants
// Widths, action codes and register offsets for the separable convolution unit.
// ----------------------------------------------------------------------------
package scc_pkg;
    localparam int MaxWidth  = 64;
    localparam int MaxHeight = 64;
    localparam int MaxRadius = 7;
    localparam int NTaps     = 2 * MaxRadius + 1;
    localparam int NPix      = MaxWidth * MaxHeight;
    localparam int WBits     = $clog2(MaxWidth + 1);
    localparam int HBits     = $clog2(MaxHeight + 1);
    localparam int ColBits   = $clog2(MaxWidth);
    localparam int RowBits   = $clog2(MaxHeight);
    localparam int AddrBits  = $clog2(NPix);
    localparam int CntBits   = $clog2(NPix + 1);
    localparam int TapBits   = $clog2(NTaps);
    localparam int RadBits   = $clog2(MaxRadius + 1);
    localparam int AccBits   = 52;

    typedef enum logic [1:0] {
        ACT_TAP   = 2'd0,
        ACT_PIXEL = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;
endpackage

// ----- sv/scc_if.sv -----
// ----------------------------------------------------------------------------
// scc_in_if / scc_out_if: request channels
// Valid/ready channels carrying input and result requests.
// ----------------------------------------------------------------------------
interface scc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [3:0]         tap_index;
    logic signed [15:0] tap_value;
    logic signed [15:0] pixel_value;
    modport source (output valid, action, tap_index, tap_value, pixel_value, input ready);
    modport sink   (input valid, action, tap_index, tap_value, pixel_value, output ready);
endinterface

interface scc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] smoothed_value;
    logic               last_of_frame;
    modport source (output valid, smoothed_value, last_of_frame, input ready);
    modport sink   (input valid, smoothed_value, last_of_frame, output ready);
endinterface

// ----- sv/scc_ram.sv -----
// ----------------------------------------------------------------------------
// scc_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module scc_ram #(
    parameter int Width = 16,
    parameter int Depth = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- sv/separable_convolution_clamped_unit.sv -----
// ----------------------------------------------------------------------------
// separable_convolution_clamped_unit: 2-D separable filter, clamp to edge
// Loads taps and a frame, runs vertical then horizontal passes on one MAC.
// ----------------------------------------------------------------------------
// Usage:
//  in channel: action 0 loads a tap, 1 loads the next pixel in raster order,
//  2 requests the next result. out channel returns one filtered pixel per
//  read request once the frame is full, with last_of_frame on the final one.
//  APB port: width at 0x0, height at 0x4, radius at 0x8; a write to one of
//  these restarts the frame. Write only while idle.
//  Tap and pixel loads pass through a load state before the next request
//  is taken. A read runs the horizontal taps on the shared MAC, then a
//  finish state; the first read after the frame (or after a tap change)
//  also runs the whole vertical pass first, one MAC per cycle over the
//  pixel RAM port, with a writeback state after each pixel.
//  A result waits in the output register; the unit takes no new request
//  until the receiver has taken it. Reset clears counters and registers to
//  64x64, radius 1; stores are undefined until written.
// ----------------------------------------------------------------------------
module separable_convolution_clamped_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scc_in_if.sink      i_req,
    scc_out_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import scc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_VMAC  = 7'b0000010,
        S_VWB   = 7'b0000100,
        S_HMAC  = 7'b0001000,
        S_HFIN  = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_LOAD  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [6:0] r_width, r_height;
    logic [2:0] r_radius;
    logic [CntBits-1:0] r_load_cnt, r_read_cnt;
    logic r_passes_done;
    logic signed [15:0] r_taps [NTaps];

    // effective geometry
    logic [WBits-1:0] eff_w;
    logic [HBits-1:0] eff_h;
    logic [RadBits-1:0] eff_r;
    logic [CntBits-1:0] n_pix;
    always_comb begin
        eff_w = (r_width == 7'd0) ? WBits'(1) :
                (r_width > 7'(MaxWidth)) ? WBits'(MaxWidth) : WBits'(r_width);
        eff_h = (r_height == 7'd0) ? HBits'(1) :
                (r_height > 7'(MaxHeight)) ? HBits'(MaxHeight) : HBits'(r_height);
        eff_r = (r_radius > 3'(MaxRadius)) ? RadBits'(MaxRadius) : RadBits'(r_radius);
        n_pix = CntBits'(eff_w * eff_h);
    end

    // APB
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = {25'd0, r_width};
            REG_HEIGHT: prdata = {25'd0, r_height};
            REG_RADIUS: prdata = {29'd0, r_radius};
            default:    prdata = 32'd0;
        endcase
    end

    // sweep position: row, column, tap
    logic [RowBits-1:0] r_row;
    logic [ColBits-1:0] r_col;
    logic [TapBits-1:0] r_tap, r_tap_d;
    logic r_mac_en;
    logic signed [AccBits-1:0] r_acc;
    logic signed [31:0] r_out;
    logic r_last;
    logic r_first;
    t_action act;
    assign act = t_action'(i_req.action);

    // read position kept as row and column beside the read count
    logic [RowBits-1:0] r_rd_row, start_row;
    logic [ColBits-1:0] r_rd_col, start_col;
    logic rd_wrap;
    assign rd_wrap = (r_read_cnt >= n_pix);
    assign start_row = rd_wrap ? '0 : r_rd_row;
    assign start_col = rd_wrap ? '0 : r_rd_col;

    // clamped neighbor index for current tap
    logic signed [11:0] off, nb;
    logic [RowBits-1:0] v_row;
    logic [ColBits-1:0] h_col;
    always_comb begin
        off = $signed({8'd0, r_tap}) - $signed({9'd0, eff_r});
        nb = r_state == S_VMAC ? $signed({1'b0, 11'(r_row)}) + off
                               : $signed({1'b0, 11'(r_col)}) + off;
        v_row = (nb < 0) ? '0 : (nb > $signed(12'(eff_h) - 12'sd1)) ?
                RowBits'(eff_h - 1'b1) : RowBits'(nb);
        h_col = (nb < 0) ? '0 : (nb > $signed(12'(eff_w) - 12'sd1)) ?
                ColBits'(eff_w - 1'b1) : ColBits'(nb);
    end

    // RAM addressing
    logic pix_we, vs_we;
    logic [AddrBits-1:0] pix_addr, vs_addr, cur_addr;
    logic [15:0] pix_rd;
    logic [23:0] vs_rd;
    logic signed [23:0] vsat;
    assign cur_addr = AddrBits'(r_row * eff_w + r_col);
    assign pix_we = (r_state == S_IDLE) && i_req.valid && i_req.ready && act == ACT_PIXEL
                    && r_load_cnt < n_pix;
    assign pix_addr = pix_we ? AddrBits'(r_load_cnt) : AddrBits'(v_row * eff_w + r_col);
    assign vs_we = (r_state == S_VWB);
    assign vs_addr = vs_we ? cur_addr : AddrBits'(r_row * eff_w + h_col);

    scc_ram #(.Width(16), .Depth(NPix)) u_pix (
        .i_clk, .i_we(pix_we), .i_addr(pix_addr),
        .i_wdata(i_req.pixel_value), .o_rdata(pix_rd));
    scc_ram #(.Width(24), .Depth(NPix)) u_vs (
        .i_clk, .i_we(vs_we), .i_addr(vs_addr),
        .i_wdata(vsat), .o_rdata(vs_rd));

    // shared MAC: operand picked by pass
    logic signed [23:0] mac_a;
    logic signed [39:0] prod;
    logic signed [AccBits-1:0] acc_nxt;
    assign mac_a = (r_state == S_VMAC || r_state == S_VWB) ?
                   24'(signed'(pix_rd)) : signed'(vs_rd);
    assign prod = mac_a * r_taps[r_tap_d];
    assign acc_nxt = (r_first ? '0 : r_acc) + AccBits'(prod);

    // floor-shift and saturate
    logic signed [AccBits-15:0] shr, shr_nxt;
    assign shr = r_acc[AccBits-1:14];
    assign shr_nxt = acc_nxt[AccBits-1:14];

    // vertical writeback value: last tap lands in the writeback cycle
    assign vsat = (shr_nxt < -(38'sd1 <<< 23)) ? 24'sh80_0000 :
                  (shr_nxt > (38'sd1 <<< 23) - 1) ? 24'sh7f_ffff : 24'(shr_nxt);

    logic tap_done, col_end, row_end;
    assign tap_done = (r_tap == TapBits'({eff_r, 1'b0}));
    assign col_end = (r_col == ColBits'(eff_w - 1'b1));
    assign row_end = (r_row == RowBits'(eff_h - 1'b1));

    assign i_req.ready = (r_state == S_IDLE) && !cfg_wr;
    assign o_res.valid = (r_state == S_OUT);
    assign o_res.smoothed_value = r_out;
    assign o_res.last_of_frame = r_last;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req.valid && i_req.ready) begin
                if (act == ACT_READ && r_load_cnt >= n_pix)
                    n_state = r_passes_done ? S_HMAC : S_VMAC;
                else n_state = S_LOAD;
            end
            S_LOAD: n_state = S_IDLE;
            S_VMAC: if (tap_done) n_state = S_VWB;
            S_VWB:  n_state = (col_end && row_end) ? S_HMAC : S_VMAC;
            S_HMAC: if (tap_done) n_state = S_HFIN;
            S_HFIN: if (!r_mac_en) n_state = S_OUT;
            S_OUT:  if (o_res.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // taps: plain registers, read at one place
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready && act == ACT_TAP && i_req.tap_index < 4'(NTaps))
            r_taps[TapBits'(i_req.tap_index)] <= i_req.tap_value;
    end

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_width <= 7'd64; r_height <= 7'd64; r_radius <= 3'd1;
            r_load_cnt <= '0; r_read_cnt <= '0; r_passes_done <= 1'b0;
            r_mac_en <= 1'b0; r_tap <= '0; r_tap_d <= '0;
            r_row <= '0; r_col <= '0;
            r_rd_row <= '0; r_rd_col <= '0;
        end else begin
            r_state <= n_state;
            r_mac_en <= (r_state == S_VMAC || r_state == S_HMAC);
            r_tap_d <= r_tap;
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_WIDTH:  r_width <= pwdata[6:0];
                    REG_HEIGHT: r_height <= pwdata[6:0];
                    REG_RADIUS: r_radius <= pwdata[2:0];
                    default: ;
                endcase
                if (paddr[3:2] != 2'd3) begin
                    r_load_cnt <= '0; r_read_cnt <= '0; r_passes_done <= 1'b0;
                    r_rd_row <= '0; r_rd_col <= '0;
                end
            end
            unique case (r_state)
                S_IDLE: if (i_req.valid && i_req.ready) begin
                    r_tap <= '0;
                    if (act == ACT_TAP && i_req.tap_index < 4'(NTaps))
                        r_passes_done <= 1'b0;
                    if (pix_we) r_load_cnt <= r_load_cnt + 1'b1;
                    if (act == ACT_READ && r_load_cnt >= n_pix) begin
                        if (!r_passes_done) begin
                            r_row <= '0; r_col <= '0;
                        end else begin
                            r_row <= start_row;
                            r_col <= start_col;
                            if (rd_wrap) begin
                                r_read_cnt <= '0; r_rd_row <= '0; r_rd_col <= '0;
                            end
                        end
                    end
                end
                S_VMAC, S_HMAC: if (!tap_done) r_tap <= r_tap + 1'b1;
                S_VWB: begin
                    r_tap <= '0;
                    if (col_end && row_end) begin
                        r_passes_done <= 1'b1;
                        r_row <= start_row;
                        r_col <= start_col;
                        if (rd_wrap) begin
                            r_read_cnt <= '0; r_rd_row <= '0; r_rd_col <= '0;
                        end
                    end else if (col_end) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                    end else r_col <= r_col + 1'b1;
                end
                S_OUT: if (o_res.ready) begin
                    if (r_last) begin
                        r_load_cnt <= '0; r_read_cnt <= '0; r_passes_done <= 1'b0;
                        r_rd_row <= '0; r_rd_col <= '0;
                    end else begin
                        r_read_cnt <= r_read_cnt + 1'b1;
                        if (r_rd_col == ColBits'(eff_w - 1'b1)) begin
                            r_rd_col <= '0;
                            r_rd_row <= r_rd_row + 1'b1;
                        end else r_rd_col <= r_rd_col + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // accumulator: starts from zero with tap 0's product, takes the last tap in the cycle after its issue
    always_ff @(posedge i_clk) begin
        r_first <= (r_tap == '0);
        if (r_mac_en) r_acc <= acc_nxt;
        if (r_state == S_HFIN && !r_mac_en) begin
            r_out <= (shr < -(38'sd1 <<< 31)) ? 32'sh8000_0000 :
                     (shr > (38'sd1 <<< 31) - 1) ? 32'sh7fff_ffff : 32'(shr);
            r_last <= (r_read_cnt == n_pix - 1'b1);
        end
    end

    // assertions
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !i_req.ready) else $error("ready during result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> $stable(r_out)) else $error("result moved");
endmodule
